// ===== src/fss_pkg.sv =====
// shared constants, types and helpers for the filtered space-saving tracker
package fss_pkg;

  localparam int MonitorSlots = 64;
  localparam int FilterSlots  = 512;
  localparam int KeyWidth     = 64;
  localparam int CountWidth   = 32;
  localparam int SlotIdxW     = $clog2(MonitorSlots);
  localparam int UsedW        = $clog2(MonitorSlots + 1);
  localparam int FiltIdxW     = $clog2(FilterSlots);
  localparam int HashW        = 9;
  localparam int RankW        = 6;
  localparam int TopKW        = 5;
  localparam int StatusW      = 3;
  localparam int MonitorRatio = 3;
  localparam int FilterRatio  = 8;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  typedef enum logic [StatusW-1:0] {
    ST_COUNTED  = 3'd0,
    ST_NEW      = 3'd1,
    ST_ABSORBED = 3'd2,
    ST_RANK_OK  = 3'd3,
    ST_RANK_NONE = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic clear_step;    // clear one filter entry, sweep address from datapath
    logic clear_start;   // restart the filter sweep and drop all slots
    logic capture;       // register the accepted request
    logic lookup;        // match / filter read cycle
    logic commit;        // apply the update and build the response
  } fss_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } fss_stat_t;

  function automatic logic [UsedW-1:0] capacity(input logic [TopKW-1:0] k);
    logic [TopKW+1:0] c;
    c = (k == '0) ? (TopKW+2)'(MonitorRatio) : (TopKW+2)'(k) * (TopKW+2)'(MonitorRatio);
    if (c > (TopKW+2)'(MonitorSlots)) c = (TopKW+2)'(MonitorSlots);
    return UsedW'(c);
  endfunction

  function automatic logic [FiltIdxW-1:0] hash_span_mask(input logic [UsedW-1:0] cap);
    logic [UsedW+3:0] need;
    logic [FiltIdxW:0] s;
    need = (UsedW+4)'(cap) * (UsedW+4)'(FilterRatio);
    s = (FiltIdxW+1)'(1);
    for (int b = 0; b < FiltIdxW; b++) begin
      if ((UsedW+4)'(s) < need) s = {s[FiltIdxW-1:0], 1'b0};
    end
    return FiltIdxW'(s - 1'b1);
  endfunction

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

endpackage

// ===== src/fss_ctrl.sv =====
// controller state machine: filter clear sweep and per-request sequencing
module fss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               in_valid_i,
  input  logic               out_free_i,
  input  fss_pkg::fss_stat_t stat_i,
  output fss_pkg::fss_cmd_t  cmd_o,
  output logic               in_ready_o
);
  import fss_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_COMMIT} state_e;
  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.lookup = 1'b1;
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free_i) begin
          cmd_o.commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      cmd_o = '0;
      cmd_o.clear_start = 1'b1;
      in_ready_o = 1'b0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// ===== src/fss_datapath.sv =====
// datapath: sorted slot registers, filter memory and response register
module fss_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fss_pkg::fss_cmd_t               cmd_i,
  output fss_pkg::fss_stat_t              stat_o,
  input  logic [fss_pkg::TopKW-1:0]       top_k_i,
  input  logic                            func_i,
  input  logic [fss_pkg::KeyWidth-1:0]    key_i,
  input  logic [fss_pkg::HashW-1:0]       hash_i,
  input  logic [fss_pkg::RankW-1:0]       rank_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            out_free_o,
  output logic [fss_pkg::StatusW-1:0]     status_o,
  output logic [fss_pkg::KeyWidth-1:0]    key_o,
  output logic [fss_pkg::CountWidth-1:0]  count_o,
  output logic [fss_pkg::RankW-1:0]       pos_o
);
  import fss_pkg::*;

  logic [KeyWidth-1:0]   skey_q  [MonitorSlots];
  logic [HashW-1:0]      shash_q [MonitorSlots];
  logic [CountWidth-1:0] scnt_q  [MonitorSlots];
  logic [UsedW-1:0]      used_q;
  logic [CountWidth-1:0] filt_mem [FilterSlots];
  logic [CountWidth-1:0] filt_rd_q;
  logic [FiltIdxW:0]     clr_q;

  logic                  func_q;
  logic [KeyWidth-1:0]   key_q;
  logic [HashW-1:0]      hash_q;
  logic [RankW-1:0]      rank_q;
  logic                  hit_q;
  logic [SlotIdxW-1:0]   hit_idx_q;

  logic                  ov_q;
  logic [StatusW-1:0]    st_q;
  logic [KeyWidth-1:0]   ko_q;
  logic [CountWidth-1:0] co_q;
  logic [RankW-1:0]      po_q;

  logic [UsedW-1:0]      cap;
  logic [UsedW-1:0]      used_eff;
  logic [FiltIdxW-1:0]   fmask;
  assign cap = capacity(top_k_i);
  assign used_eff = (used_q > cap) ? cap : used_q;
  assign fmask = hash_span_mask(cap);

  // parallel key match over occupied slots
  logic                  hit_c;
  logic [SlotIdxW-1:0]   hit_idx_c;
  always_comb begin
    hit_c = 1'b0;
    hit_idx_c = '0;
    for (int s = MonitorSlots - 1; s >= 0; s--) begin
      if (UsedW'(s) < used_eff && skey_q[s] == key_q) begin
        hit_c = 1'b1;
        hit_idx_c = SlotIdxW'(s);
      end
    end
  end

  // commit-cycle decision
  logic                  full;
  logic [SlotIdxW-1:0]   tgt;
  logic [SlotIdxW-1:0]   min_idx;
  logic [CountWidth-1:0] minc;
  logic [CountWidth-1:0] newc;
  logic                  absorb;
  logic                  do_slot;
  logic [SlotIdxW-1:0]   dest;
  logic                  rank_ok;

  assign full    = (used_eff == cap);
  assign min_idx = SlotIdxW'(used_eff - 1'b1);
  assign minc    = scnt_q[min_idx];
  assign absorb  = !hit_q && full && (filt_rd_q < minc) &&
                   ((minc - filt_rd_q) > CountWidth'(1));
  assign do_slot = !func_q && !absorb;
  assign tgt     = hit_q ? hit_idx_q : (full ? min_idx : SlotIdxW'(used_eff));
  assign newc    = hit_q ? sat_inc(scnt_q[hit_idx_q]) :
                   (full ? sat_inc(minc) : CountWidth'(1));
  assign rank_ok = (UsedW'(rank_q) < used_eff) &&
                   ({1'b0, rank_q} < ((top_k_i == '0) ? (RankW+1)'(1) : (RankW+1)'(top_k_i)));

  // rank after the move: first slot above tgt whose count is below newc
  always_comb begin
    dest = tgt;
    for (int s = MonitorSlots - 1; s >= 0; s--) begin
      if (SlotIdxW'(s) < tgt && scnt_q[s] < newc) dest = SlotIdxW'(s);
    end
  end

  assign stat_o.clear_done = clr_q[FiltIdxW];
  assign out_free_o = !ov_q || out_ready_i;

  // filter memory, one write port and one registered read
  logic                  fwe;
  logic [FiltIdxW-1:0]   fwa;
  logic [CountWidth-1:0] fwd;
  always_comb begin
    fwe = 1'b0;
    fwa = '0;
    fwd = '0;
    if (cmd_i.clear_step) begin
      fwe = 1'b1;
      fwa = clr_q[FiltIdxW-1:0];
    end else if (cmd_i.commit && !func_q && !hit_q && full) begin
      fwe = 1'b1;
      if (absorb) begin
        fwa = hash_q[FiltIdxW-1:0] & fmask;
        fwd = sat_inc(filt_rd_q);
      end else begin
        fwa = shash_q[min_idx][FiltIdxW-1:0] & fmask;
        fwd = minc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fwe) filt_mem[fwa] <= fwd;
    if (cmd_i.lookup) filt_rd_q <= filt_mem[hash_q[FiltIdxW-1:0] & fmask];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      used_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (cmd_i.clear_start) begin
        clr_q  <= '0;
        used_q <= '0;
      end else if (cmd_i.clear_step && !clr_q[FiltIdxW]) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.commit) begin
        ov_q <= 1'b1;
        if (do_slot && !hit_q && !full) used_q <= used_eff + 1'b1;
        else if (do_slot) used_q <= used_eff;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // slot array: one shift of the range dest..tgt per update
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      key_q  <= key_i;
      hash_q <= hash_i;
      rank_q <= rank_i;
    end
    if (cmd_i.lookup) begin
      hit_q     <= hit_c;
      hit_idx_q <= hit_idx_c;
    end
    if (cmd_i.commit) begin
      if (do_slot) begin
        for (int s = 0; s < MonitorSlots; s++) begin
          if (SlotIdxW'(s) == dest) begin
            skey_q[s]  <= key_q;
            shash_q[s] <= hit_q ? shash_q[tgt] : hash_q;
            scnt_q[s]  <= newc;
          end else if (s > 0 && SlotIdxW'(s) > dest && SlotIdxW'(s) <= tgt) begin
            skey_q[s]  <= skey_q[SlotIdxW'(s - 1)];
            shash_q[s] <= shash_q[SlotIdxW'(s - 1)];
            scnt_q[s]  <= scnt_q[SlotIdxW'(s - 1)];
          end
        end
      end
      if (func_q) begin
        st_q <= rank_ok ? ST_RANK_OK : ST_RANK_NONE;
        ko_q <= rank_ok ? skey_q[rank_q] : '0;
        co_q <= rank_ok ? scnt_q[rank_q] : '0;
        po_q <= rank_q;
      end else if (absorb) begin
        st_q <= ST_ABSORBED;
        ko_q <= key_q;
        co_q <= sat_inc(filt_rd_q);
        po_q <= '0;
      end else begin
        st_q <= hit_q ? ST_COUNTED : ST_NEW;
        ko_q <= key_q;
        co_q <= newc;
        po_q <= RankW'(dest);
      end
    end
  end

  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign key_o = ko_q;
  assign count_o = co_q;
  assign pos_o = po_q;
endmodule

// ===== src/filtered_space_saving_topk_core.sv =====
// top level of the filtered space-saving top-k tracker
//   channel | dir | handshake              | payload
//   s_axis  | in  | s_axis_tvalid/tready   | tdata {rank,key_hash,key}, tuser func
//   m_axis  | out | m_axis_tvalid/tready   | tdata {position,count_out,key_out}, tuser status
//   cfg     | in  | cfg_we_i               | cfg_wdata_i = top_k
// each request passes the steps capture, lookup (key match and filter memory read),
// commit (slot shift, filter write, response register)
// after reset and after every top_k write the filter memory is swept, at one entry a
// cycle, with no request accepted
// a response waits in the output register; commit holds while it is not taken
module filtered_space_saving_topk_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fss_pkg::TopKW-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // key [63:0], key_hash [72:64], rank [78:73], zero fill
  input  logic [79:0]                    s_axis_tdata,
  // func
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // key_out [63:0], count_out [95:64], position [101:96], zero fill
  output logic [103:0]                   m_axis_tdata,
  // status [2:0]
  output logic [2:0]                     m_axis_tuser
);
  import fss_pkg::*;

  logic [TopKW-1:0] top_k_q;
  fss_cmd_t  cmd;
  fss_stat_t stat;
  logic out_free;
  logic [StatusW-1:0] st;
  logic [KeyWidth-1:0] ko;
  logic [CountWidth-1:0] co;
  logic [RankW-1:0] po;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_k_q <= TopKW'(10);
    end else if (cfg_we_i) begin
      top_k_q <= cfg_wdata_i;
    end
  end

  fss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (s_axis_tready)
  );

  fss_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .top_k_i     (top_k_q),
    .func_i      (s_axis_tuser),
    .key_i       (s_axis_tdata[63:0]),
    .hash_i      (s_axis_tdata[72:64]),
    .rank_i      (s_axis_tdata[78:73]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_free_o  (out_free),
    .status_o    (st),
    .key_o       (ko),
    .count_o     (co),
    .pos_o       (po)
  );

  assign m_axis_tdata = {2'b0, po, co, ko};
  assign m_axis_tuser = st;
endmodule

// ===== src/fss_checker.sv =====
// port-level checks for the tracker, bound to the top level
module fss_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cfg_we_i,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser))
    else $error("response dropped or changed while stalled");

  a_no_accept_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("request accepted during filter sweep");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request accepted while one is in flight");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= 3'd4)
    else $error("status code out of range");
endmodule

bind filtered_space_saving_topk_core fss_checker u_fss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
